### design/button_edge_event_queue_assert.svh
// assertion macros for the button edge event queue checker
// depends on clk and arst_n being visible where the macros are used
`ifndef BUTTON_EDGE_EVENT_QUEUE_ASSERT_SVH
`define BUTTON_EDGE_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication
`define BEVQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BEVQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bevq_pkg.sv
// shared types, constants and the button uid table for the button edge event queue
// no dependencies
package bevq_pkg;

	localparam int NUM_BUTTONS         = 11;
	localparam int IDX_W               = 4;
	localparam int UID_W               = 25;
	localparam int ENTRY_W             = IDX_W + 1;
	localparam int DEFAULT_QUEUE_DEPTH = 64;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	localparam logic [31:0] UID_TABLE [NUM_BUTTONS] = '{
		32'h0106C3FE, 32'h0106C400, 32'h0106C3FF, 32'h0106C401,
		32'h0106C402, 32'h0106C406, 32'h0106C408, 32'h0106C40A,
		32'h0106C40B, 32'h0106C40C, 32'h0106C40D
	};

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
		logic             pressed;
	} bevq_push_t;

	function automatic logic [UID_W-1:0] bevq_uid(input logic [IDX_W-1:0] idx);
		logic [UID_W-1:0] uid;
		uid = '0;
		if (idx < IDX_W'(NUM_BUTTONS)) begin
			uid = UID_TABLE[idx][UID_W-1:0];
		end
		return uid;
	endfunction

endpackage

### design/bevq_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module bevq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/bevq_scan.sv
// level change scanner: keeps the previous pad levels and walks the change mask
// one button per cycle; depends on bevq_pkg
module bevq_scan
	import bevq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUM_BUTTONS-1:0] levels,
	output bevq_push_t             push,
	output logic                   done
);

	logic [NUM_BUTTONS-1:0] prev_q;
	logic [NUM_BUTTONS-1:0] mask_q;
	logic [NUM_BUTTONS-1:0] lev_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   active_q;
	logic                   last;

	assign last         = idx_q == IDX_W'(NUM_BUTTONS - 1);
	assign done         = active_q && last;
	assign push.valid   = active_q && mask_q[idx_q];
	assign push.index   = idx_q;
	assign push.pressed = lev_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (start) begin
			prev_q   <= levels;
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q) begin
			idx_q <= idx_q + 1'b1;
			if (last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= levels ^ prev_q;
			lev_q  <= levels;
		end
	end

endmodule

### design/button_edge_event_queue.sv
// top level of the button edge event queue: fifo control around the event ram
// depends on bevq_pkg, bevq_ram, bevq_scan
//
// channel  dir  tdata                                           tuser
// s_axis   in   [10:0] buttons                                  [0] func
// m_axis   out  [3:0] index, [4] pressed, [29:5] uid, [30] drop  [0] status
//
// update: accept, then the scanner walks one button per cycle, with one ram write
// per changed button while the queue is not full (a full queue sets the drop flag)
// pop: ram read on accept, then result into the output register
// reset clears levels, pointers, count and drop flag; the event ram is not cleared
// a stalled output holds the pop in its read state until the register frees up
module button_edge_event_queue
	import bevq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [10:0] buttons
	input  logic        s_axis_tuser,  // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [3:0] button_index, [4] pressed,
	                                   // [29:5] uid, [30] events_dropped
	output logic        m_axis_tuser   // [0] status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_POP  = 3'b100
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;

	logic             out_valid_q;
	logic             out_status_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_pressed_q;
	logic [UID_W-1:0] out_uid_q;
	logic             out_dropped_q;

	logic               in_acc;
	logic               upd_start;
	logic               pop_start;
	logic               full;
	logic               empty;
	logic               out_free;
	logic               pop_done;
	logic               wr_en;
	bevq_push_t         push;
	logic               scan_done;
	logic [ENTRY_W-1:0] rd_data;

	assign s_axis_tready = state_q == ST_IDLE;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign upd_start     = in_acc && s_axis_tuser == FUNC_UPDATE;
	assign pop_start     = in_acc && s_axis_tuser == FUNC_POP;
	assign full          = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty         = count_q == '0;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign pop_done      = state_q == ST_POP && out_free;
	assign wr_en         = push.valid && !full;

	bevq_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (upd_start),
		.levels (s_axis_tdata[NUM_BUTTONS-1:0]),
		.push   (push),
		.done   (scan_done)
	);

	bevq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_ptr_q),
		.wr_data ({push.pressed, push.index}),
		.rd_en   (pop_start),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (upd_start) begin
					state_d = ST_SCAN;
				end else if (pop_start) begin
					state_d = ST_POP;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push.valid) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
					count_q  <= count_q + 1'b1;
				end
			end
			if (pop_done) begin
				out_valid_q <= 1'b1;
				if (!empty) begin
					rd_ptr_q  <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
					count_q   <= count_q - 1'b1;
					dropped_q <= 1'b0;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_done) begin
			if (empty) begin
				out_status_q  <= STATUS_EMPTY;
				out_idx_q     <= '0;
				out_pressed_q <= 1'b0;
				out_uid_q     <= '0;
				out_dropped_q <= 1'b0;
			end else begin
				out_status_q  <= STATUS_OK;
				out_idx_q     <= rd_data[IDX_W-1:0];
				out_pressed_q <= rd_data[IDX_W];
				out_uid_q     <= bevq_uid(rd_data[IDX_W-1:0]);
				out_dropped_q <= dropped_q;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {1'b0, out_dropped_q, out_uid_q, out_pressed_q, out_idx_q};

endmodule

### design/bevq_checker.sv
// port-level checks for the button edge event queue, bound to the top level
// depends on bevq_pkg and button_edge_event_queue_assert.svh
`include "button_edge_event_queue_assert.svh"

module bevq_checker
	import bevq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	logic upd_acc;
	logic out_stall;

	assign upd_acc   = s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_UPDATE
		&& s_axis_tdata[15] == s_axis_tdata[15];
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`BEVQ_ASSERT_NEXT(a_out_hold, out_stall,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result transaction changed")
	`BEVQ_ASSERT_NOW(a_empty_zero, m_axis_tvalid && m_axis_tuser == STATUS_EMPTY,
		m_axis_tdata == '0, "empty status with nonzero fields")
	`BEVQ_ASSERT_NOW(a_index_range, m_axis_tvalid && m_axis_tuser == STATUS_OK,
		m_axis_tdata[3:0] < IDX_W'(NUM_BUTTONS) && m_axis_tdata[29:5] != '0,
		"event index out of table")
	`BEVQ_ASSERT_NEXT(a_scan_busy, upd_acc, !s_axis_tready,
		"input taken during update scan")

endmodule

bind button_edge_event_queue bevq_checker u_bevq_checker (.*);

### tb/tb_button_edge_event_queue.sv
// self-checking testbench for button_edge_event_queue: directed rows, then random bursts of
// pad updates and event pops with random stalls on both stream ports
// depends on bevq_pkg and button_edge_event_queue
`timescale 1ns / 1ps

module tb_button_edge_event_queue;
	import bevq_pkg::*;

	localparam int EVENT_DEPTH  = DEFAULT_QUEUE_DEPTH;
	localparam int RANDOM_ITEMS = 900;

	localparam logic [24:0] BUTTON_UIDS [11] = '{
		25'h106C3FE, 25'h106C400, 25'h106C3FF, 25'h106C401,
		25'h106C402, 25'h106C406, 25'h106C408, 25'h106C40A,
		25'h106C40B, 25'h106C40C, 25'h106C40D
	};

	typedef struct packed {
		logic        status;
		logic [3:0]  index;
		logic        pressed;
		logic [24:0] uid;
		logic        dropped;
	} pop_result_t;

	typedef struct packed {
		logic        func;
		logic [10:0] levels;
		logic        typed;
		pop_result_t result;
	} directed_row_t;

	localparam pop_result_t NOT_TYPED  = '0;
	localparam pop_result_t EMPTY_POP  = '{STATUS_EMPTY, 4'd0, 1'b0, 25'd0, 1'b0};
	localparam pop_result_t UP_PRESSED = '{STATUS_OK, 4'd0, 1'b1, 25'h106C3FE, 1'b0};
	localparam pop_result_t DN_PRESSED = '{STATUS_OK, 4'd1, 1'b1, 25'h106C400, 1'b0};

	localparam directed_row_t DIRECTED_ROWS [20] = '{
		'{FUNC_POP,    11'h000, 1'b1, EMPTY_POP},
		'{FUNC_POP,    11'h7FF, 1'b1, EMPTY_POP},
		'{FUNC_UPDATE, 11'h7FF, 1'b0, NOT_TYPED},
		'{FUNC_POP,    11'h000, 1'b1, UP_PRESSED},
		'{FUNC_POP,    11'h000, 1'b1, DN_PRESSED},
		'{FUNC_UPDATE, 11'h000, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h7FF, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h000, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h7FF, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h000, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h7FF, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h7FF, 1'b0, NOT_TYPED},
		'{FUNC_POP,    11'h000, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h000, 1'b0, NOT_TYPED},
		'{FUNC_POP,    11'h000, 1'b0, NOT_TYPED},
		'{FUNC_POP,    11'h000, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h555, 1'b0, NOT_TYPED},
		'{FUNC_UPDATE, 11'h2AA, 1'b0, NOT_TYPED},
		'{FUNC_POP,    11'h555, 1'b0, NOT_TYPED},
		'{FUNC_POP,    11'h2AA, 1'b0, NOT_TYPED}
	};

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;  // [10:0] buttons
	logic        s_axis_tuser  = FUNC_UPDATE;  // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // [3:0] button_index, [4] pressed, [29:5] uid,
	                            // [30] events_dropped
	logic        m_axis_tuser;  // [0] status

	logic [10:0] held_levels = '0;
	logic [4:0]  queued_events[$];
	logic        lost_events = 1'b0;
	pop_result_t expected_pops[$];
	bit          quiet_phase = 1'b0;
	bit          failed = 1'b0;

	button_edge_event_queue #(
		.QUEUE_DEPTH(EVENT_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// queue behavior: one event per changed button in index order, drop when full
	function automatic void track_pad_item(input logic func, input logic [10:0] levels,
			output logic has_result, output pop_result_t result);
		logic [4:0] entry;
		has_result = 1'b0;
		result = '0;
		if (func == FUNC_UPDATE) begin
			for (int i = 0; i < 11; i++) begin
				if (held_levels[i] != levels[i]) begin
					if (queued_events.size() >= EVENT_DEPTH) begin
						lost_events = 1'b1;
					end else begin
						queued_events.insert(queued_events.size(), {levels[i], 4'(i)});
					end
				end
			end
			held_levels = levels;
		end else begin
			has_result = 1'b1;
			if (queued_events.size() == 0) begin
				result.status = STATUS_EMPTY;
			end else begin
				entry = queued_events[0];
				queued_events.delete(0);
				result.status  = STATUS_OK;
				result.index   = entry[3:0];
				result.pressed = entry[4];
				result.uid     = (entry[3:0] < 4'd11) ? BUTTON_UIDS[entry[3:0]] : 25'd0;
				result.dropped = lost_events;
				lost_events = 1'b0;
			end
		end
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [10:0] next_levels();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			return 11'($urandom);
		end
		if (r < 50) begin
			return held_levels ^ (11'd1 << $urandom_range(0, 10));
		end
		if (r < 65) begin
			return ~held_levels;
		end
		if (r < 75) begin
			return held_levels;
		end
		return held_levels ^ 11'($urandom);
	endfunction

	task automatic send_item(input logic func, input logic [10:0] levels, input logic typed,
			input pop_result_t typed_result);
		int          gap;
		logic        has_result;
		pop_result_t predicted;
		gap = quiet_phase ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, levels};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		track_pad_item(func, levels, has_result, predicted);
		if (has_result) begin
			expected_pops.insert(expected_pops.size(), typed ? typed_result : predicted);
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	// output transaction checker
	always @(posedge clk) begin : result_check
		pop_result_t got;
		pop_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[29:5],
				m_axis_tdata[30]};
			if (expected_pops.size() == 0) begin
				$error("unexpected result transaction: tdata 0x%h tuser %b",
					m_axis_tdata, m_axis_tuser);
				failed = 1'b1;
			end else begin
				want = expected_pops[0];
				expected_pops.delete(0);
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("button_index", 32'(want.index), 32'(got.index));
				check_field("pressed", 32'(want.pressed), 32'(got.pressed));
				check_field("uid", 32'(want.uid), 32'(got.uid));
				check_field("events_dropped", 32'(want.dropped), 32'(got.dropped));
			end
		end
	end

	// output backpressure
	initial begin : sink_pacing
		int hold;
		int unsigned r;
		hold = 0;
		forever begin
			@(posedge clk);
			if (quiet_phase) begin
				m_axis_tready <= 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				hold--;
			end else if (m_axis_tready) begin
				m_axis_tready <= 1'b0;
				r = $urandom_range(0, 99);
				hold = (r < 60) ? $urandom_range(0, 2) :
					(r < 92) ? $urandom_range(3, 6) : $urandom_range(10, 40);
			end else begin
				m_axis_tready <= 1'b1;
				hold = $urandom_range(0, 7);
			end
		end
	end

	initial begin : stimulus
		int          sent;
		int          burst_len;
		int          pop_pct;
		logic        func;
		logic [10:0] levels;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED_ROWS[i]) begin
			send_item(DIRECTED_ROWS[i].func, DIRECTED_ROWS[i].levels, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].result);
		end
		// bursts that lean toward filling, draining or a mix of both
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet_phase = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: pop_pct = 15;
				1: pop_pct = 85;
				default: pop_pct = 50;
			endcase
			burst_len = $urandom_range(10, 60);
			repeat (burst_len) begin
				if ($urandom_range(0, 99) < pop_pct) begin
					func = FUNC_POP;
					levels = 11'($urandom);
				end else begin
					func = FUNC_UPDATE;
					levels = next_levels();
				end
				send_item(func, levels, 1'b0, NOT_TYPED);
				sent++;
			end
		end
		quiet_phase = 1'b0;
		s_axis_tvalid <= 1'b0;
		while (expected_pops.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (failed) begin
			$display("tb_button_edge_event_queue: FAIL");
		end else begin
			$display("tb_button_edge_event_queue: PASS");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb_button_edge_event_queue: FAIL");
		$finish;
	end

endmodule
